// File: rtl/mbrf_pkg.sv
// ----------------------------------------------------------------------------
// Modbus request framer package
// Frame kinds, CRC-16/MODBUS constants and lookup table, frame byte selection.
// ----------------------------------------------------------------------------
package mbrf_pkg;

    localparam logic [1:0] KIND_WRITE16 = 2'd0;
    localparam logic [1:0] KIND_WRITE32 = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Byte index within a frame; a frame is at most 13 bytes long.
    localparam int IDX_W = 4;
    typedef logic [IDX_W-1:0] idx_t;

    // Index of the low CRC byte, which is also the number of data bytes.
    localparam idx_t CRC_IDX_SHORT = 4'd6;
    localparam idx_t CRC_IDX_LONG  = 4'd11;

    localparam logic [7:0] WR32_COUNT_HI = 8'h00;
    localparam logic [7:0] WR32_COUNT_LO = 8'h02;
    localparam logic [7:0] WR32_BYTES    = 8'h04;

    typedef logic [255:0][15:0] crc_table_t;

    typedef struct packed {
        logic init;
        logic update;
    } crc_ctrl_t;

    // Byte-wise table for the reflected polynomial, built at elaboration.
    function automatic crc_table_t build_crc_table();
        crc_table_t tbl;
        logic [15:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 16'(i);
            for (int b = 0; b < 8; b++) begin
                if (c[0])
                    c = (c >> 1) ^ CRC_POLY;
                else
                    c = c >> 1;
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = build_crc_table();

    // Data byte at a given frame position (CRC bytes are handled elsewhere).
    function automatic logic [7:0] frame_data_byte(
        input logic [1:0]  kind,
        input idx_t        idx,
        input logic [7:0]  dev,
        input logic [7:0]  fc,
        input logic [15:0] reg_addr,
        input logic [31:0] val
    );
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0: b = dev;
            4'd1: b = fc;
            4'd2: b = reg_addr[15:8];
            4'd3: b = reg_addr[7:0];
            4'd4: b = (kind == KIND_WRITE32) ? WR32_COUNT_HI : val[15:8];
            4'd5: b = (kind == KIND_WRITE32) ? WR32_COUNT_LO : val[7:0];
            4'd6: b = WR32_BYTES;
            4'd7: b = val[31:24];
            4'd8: b = val[23:16];
            4'd9: b = val[15:8];
            4'd10: b = val[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/mbrf_crc_unit.sv
// ----------------------------------------------------------------------------
// CRC-16/MODBUS unit
// Byte-at-a-time CRC register, updated by table lookup on command.
// ----------------------------------------------------------------------------
module mbrf_crc_unit
    import mbrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctrl_t   ctrl,
    input  logic [7:0]  data,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  lookup;

    assign lookup = crc_reg[7:0] ^ data;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.init)
            crc_next = CRC_INIT;
        else if (ctrl.update)
            crc_next = (crc_reg >> 8) ^ CRC_TABLE[lookup];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

// File: rtl/modbus_request_framer.sv
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Turns one request into its RTU frame bytes followed by the CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// On a request transfer the sequencer enters its sending state, then the first
// byte is loaded into the output register. One byte per cycle with no stall;
// 8 bytes for read and 16-bit writes, 13 for 32-bit writes. A new request is
// taken once the last byte is loaded. The CRC table step takes each data byte.
// Requests of the unused kind are taken and dropped with no bytes.
// Reset returns the sequencer to idle and empties the output register.
module modbus_request_framer
    import mbrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  device_address,
    input  logic [7:0]  function_code,
    input  logic [15:0] register_address,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic        state_reg, state_next;
    idx_t        idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;

    logic [1:0]  kind_reg;
    logic [7:0]  dev_reg;
    logic [7:0]  fc_reg;
    logic [15:0] addr_reg;
    logic [31:0] val_reg;

    logic        accept;
    logic        load;
    logic        data_phase;
    idx_t        crc_idx;
    idx_t        last_idx;
    logic [7:0]  data_byte;
    logic [15:0] crc;
    crc_ctrl_t   crc_ctrl;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // A byte moves into the output register when it is empty or being drained.
    assign load       = (state_reg == ST_SEND) && (!out_valid_reg || out_ready);
    assign crc_idx    = (kind_reg == KIND_WRITE32) ? CRC_IDX_LONG : CRC_IDX_SHORT;
    assign last_idx   = crc_idx + idx_t'(1);
    assign data_phase = (idx_reg < crc_idx);
    assign data_byte  = frame_data_byte(kind_reg, idx_reg, dev_reg, fc_reg,
                                        addr_reg, val_reg);

    assign crc_ctrl.init   = accept;
    assign crc_ctrl.update = load && data_phase;

    mbrf_crc_unit u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (data_byte),
        .crc   (crc)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (accept && (func != KIND_UNUSED))
        begin
            state_next = ST_SEND;
            idx_next   = '0;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            if (data_phase)
                byte_next = data_byte;
            else if (idx_reg == crc_idx)
                byte_next = crc[7:0];
            else
                byte_next = crc[15:8];
            last_next = (idx_reg == last_idx);
            idx_next  = idx_reg + idx_t'(1);
            if (idx_reg == last_idx)
                state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        if (accept)
        begin
            kind_reg <= func;
            dev_reg  <= device_address;
            fc_reg   <= function_code;
            addr_reg <= register_address;
            val_reg  <= value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last       = last_reg;

    // A valid request starts its frame at the first byte.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func != KIND_UNUSED) |=> (state_reg == ST_SEND && idx_reg == '0))
        else $error("frame did not start at byte zero");

    // The byte counter never runs past the final CRC byte.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> (idx_reg <= last_idx))
        else $error("byte index beyond end of frame");

    // Loading the final byte ends the frame and frees the input side.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && idx_reg == last_idx) |=> (in_ready && out_valid && last))
        else $error("frame did not end on its last byte");

    // The unused kind never gets into the sending state.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> (kind_reg != KIND_UNUSED))
        else $error("sending a frame of the unused kind");

endmodule
